[hw/rtl/tgarle_pkg.sv]
`timescale 1ns / 1ps

package tgarle_pkg;

   // image size arithmetic
   localparam int DIM_BITS = 16;
   localparam int TOTAL_W  = 2 * DIM_BITS;
   localparam int PIX_W    = 32;
   localparam int REG_W    = 16;

   // packet header decoding
   localparam logic [7:0] RAW_LIMIT = 8'd128;
   localparam logic [7:0] RUN_BIAS  = 8'd127;

   // colour byte layout
   localparam logic [2:0] BPP_WITH_ALPHA = 3'd4;
   localparam logic [1:0] LAST_IDX_RGB   = 2'd2;
   localparam logic [1:0] LAST_IDX_RGBA  = 2'd3;

   // register indexes
   localparam logic [1:0] CSR_BYTES_PER_PIXEL = 2'd0;
   localparam logic [1:0] CSR_IMAGE_WIDTH     = 2'd1;
   localparam logic [1:0] CSR_IMAGE_HEIGHT    = 2'd2;

   // settings seen by the decoder
   typedef struct packed {
      logic                 has_alpha;
      logic [TOTAL_W-1:0]   total_pixels;
   } cfg_type;

endpackage

[hw/rtl/tgarle_cfg.sv]
`timescale 1ns / 1ps

module tgarle_cfg (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [1:0]                   csr_addr,
   input  logic [tgarle_pkg::REG_W-1:0] csr_wdata,
   output tgarle_pkg::cfg_type          cfg
);

   logic                                 has_alpha_ff;
   logic [tgarle_pkg::DIM_BITS-1:0]      width_ff;
   logic [tgarle_pkg::DIM_BITS-1:0]      height_ff;
   logic [tgarle_pkg::TOTAL_W-1:0]       total_ff;
   logic [tgarle_pkg::DIM_BITS-1:0]      wdata_dim;

   assign wdata_dim = csr_wdata[tgarle_pkg::DIM_BITS-1:0];

   // size registers and the pixel total, updated on the same edge as the write
   always_ff @(posedge clock) begin
      if (reset) begin
         has_alpha_ff <= 1'b0;
         width_ff     <= tgarle_pkg::DIM_BITS'(1);
         height_ff    <= tgarle_pkg::DIM_BITS'(1);
         total_ff     <= tgarle_pkg::TOTAL_W'(1);
      end else if (csr_we) begin
         case (csr_addr)
            tgarle_pkg::CSR_BYTES_PER_PIXEL: begin
               has_alpha_ff <= (csr_wdata[2:0] == tgarle_pkg::BPP_WITH_ALPHA);
            end
            tgarle_pkg::CSR_IMAGE_WIDTH: begin
               width_ff <= wdata_dim;
               total_ff <= tgarle_pkg::TOTAL_W'(wdata_dim) *
                           tgarle_pkg::TOTAL_W'(height_ff);
            end
            tgarle_pkg::CSR_IMAGE_HEIGHT: begin
               height_ff <= wdata_dim;
               total_ff  <= tgarle_pkg::TOTAL_W'(width_ff) *
                            tgarle_pkg::TOTAL_W'(wdata_dim);
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg.has_alpha    = has_alpha_ff;
   assign cfg.total_pixels = total_ff;

endmodule

[hw/rtl/tgarle_decode.sv]
`timescale 1ns / 1ps

module tgarle_decode (
   input  logic                clock,
   input  logic                reset,
   input  tgarle_pkg::cfg_type cfg,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,
   input  logic                req_tuser,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [39:0]         rsp_tdata,
   output logic                rsp_tlast,
   output logic                rsp_tuser
);

   // input register
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;
   logic       in_first_ff;
   logic       go;

   // decoder state
   logic                         phase_ff,   phase_in;
   logic                         run_ff,     run_in;
   logic [7:0]                   left_ff,    left_in;
   logic [1:0]                   idx_ff,     idx_in;
   logic [7:0]                   buf0_ff,    buf0_in;
   logic [7:0]                   buf1_ff,    buf1_in;
   logic [7:0]                   buf2_ff,    buf2_in;
   logic [tgarle_pkg::PIX_W-1:0] decoded_ff, decoded_in;
   logic                         fin_ff,     fin_in;

   // result register
   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] red_ff,    red_in;
   logic [7:0] green_ff,  green_in;
   logic [7:0] blue_ff,   blue_in;
   logic [7:0] alpha_ff,  alpha_in;
   logic [7:0] repeat_ff, repeat_in;
   logic       done_ff,   done_in;
   logic       ovf_ff,    ovf_in;

   // working values
   logic                         e_phase, e_run, e_fin;
   logic [7:0]                   e_left, e_buf0, e_buf1, e_buf2;
   logic [1:0]                   e_idx;
   logic [tgarle_pkg::PIX_W-1:0] e_decoded;
   logic [1:0]                   last_idx;
   logic [7:0]                   hdr_count, pix_count, add_count;
   logic [tgarle_pkg::PIX_W:0]   sum_wide;
   logic [tgarle_pkg::PIX_W:0]   total_wide;

   // the decoder moves when the result slot is free or being emptied
   assign go         = in_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || go;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tvalid && req_tready) begin
         in_valid_ff <= 1'b1;
      end else if (go) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff  <= req_tdata;
         in_first_ff <= req_tuser;
      end
   end

   // a first-of-image mark clears the state before the byte is taken
   always_comb begin
      e_phase   = in_first_ff ? 1'b0 : phase_ff;
      e_run     = in_first_ff ? 1'b0 : run_ff;
      e_left    = in_first_ff ? 8'd0 : left_ff;
      e_idx     = in_first_ff ? 2'd0 : idx_ff;
      e_buf0    = in_first_ff ? 8'd0 : buf0_ff;
      e_buf1    = in_first_ff ? 8'd0 : buf1_ff;
      e_buf2    = in_first_ff ? 8'd0 : buf2_ff;
      e_decoded = in_first_ff ? '0 : decoded_ff;
      e_fin     = in_first_ff ? 1'b0 : fin_ff;
   end

   // header count, pixel count and the running pixel total
   always_comb begin
      last_idx   = cfg.has_alpha ? tgarle_pkg::LAST_IDX_RGBA : tgarle_pkg::LAST_IDX_RGB;
      hdr_count  = (in_byte_ff < tgarle_pkg::RAW_LIMIT) ? (in_byte_ff + 8'd1)
                                                        : (in_byte_ff - tgarle_pkg::RUN_BIAS);
      pix_count  = e_run ? e_left : 8'd1;
      add_count  = e_phase ? pix_count : hdr_count;
      sum_wide   = {1'b0, e_decoded} + (tgarle_pkg::PIX_W + 1)'(add_count);
      total_wide = (tgarle_pkg::PIX_W + 1)'(cfg.total_pixels);
   end

   // packet decoding
   always_comb begin
      phase_in     = e_phase;
      run_in       = e_run;
      left_in      = e_left;
      idx_in       = e_idx;
      buf0_in      = e_buf0;
      buf1_in      = e_buf1;
      buf2_in      = e_buf2;
      decoded_in   = e_decoded;
      fin_in       = e_fin;
      rsp_valid_in = 1'b0;
      red_in       = 8'd0;
      green_in     = 8'd0;
      blue_in      = 8'd0;
      alpha_in     = 8'd0;
      repeat_in    = 8'd0;
      done_in      = 1'b0;
      ovf_in       = 1'b0;
      if (!e_fin) begin
         if (!e_phase) begin
            // packet header
            if (sum_wide > total_wide) begin
               rsp_valid_in = 1'b1;
               ovf_in       = 1'b1;
               fin_in       = 1'b1;
            end else begin
               run_in   = in_byte_ff[7];
               left_in  = hdr_count;
               idx_in   = 2'd0;
               phase_in = 1'b1;
            end
         end else if (e_idx < last_idx) begin
            // colour byte other than the last
            case (e_idx)
               2'd0:    buf0_in = in_byte_ff;
               2'd1:    buf1_in = in_byte_ff;
               2'd2:    buf2_in = in_byte_ff;
               default: begin
               end
            endcase
            idx_in = e_idx + 2'd1;
         end else begin
            // final colour byte completes the pixel
            if (!cfg.has_alpha) begin
               buf2_in = in_byte_ff;
            end
            rsp_valid_in = 1'b1;
            red_in       = cfg.has_alpha ? e_buf2 : in_byte_ff;
            green_in     = e_buf1;
            blue_in      = e_buf0;
            alpha_in     = cfg.has_alpha ? in_byte_ff : 8'd0;
            repeat_in    = pix_count;
            decoded_in   = sum_wide[tgarle_pkg::PIX_W-1:0];
            idx_in       = 2'd0;
            if (e_run || (e_left <= 8'd1)) begin
               left_in  = 8'd0;
               phase_in = 1'b0;
            end else begin
               left_in = e_left - 8'd1;
            end
            done_in = (sum_wide[tgarle_pkg::PIX_W-1:0] >=
                       tgarle_pkg::PIX_W'(cfg.total_pixels));
            fin_in  = done_in;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= 1'b0;
         run_ff     <= 1'b0;
         left_ff    <= 8'd0;
         idx_ff     <= 2'd0;
         buf0_ff    <= 8'd0;
         buf1_ff    <= 8'd0;
         buf2_ff    <= 8'd0;
         decoded_ff <= '0;
         fin_ff     <= 1'b0;
      end else if (go) begin
         phase_ff   <= phase_in;
         run_ff     <= run_in;
         left_ff    <= left_in;
         idx_ff     <= idx_in;
         buf0_ff    <= buf0_in;
         buf1_ff    <= buf1_in;
         buf2_ff    <= buf2_in;
         decoded_ff <= decoded_in;
         fin_ff     <= fin_in;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (go) begin
         rsp_valid_ff <= rsp_valid_in;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (go && rsp_valid_in) begin
         red_ff    <= red_in;
         green_ff  <= green_in;
         blue_ff   <= blue_in;
         alpha_ff  <= alpha_in;
         repeat_ff <= repeat_in;
         done_ff   <= done_in;
         ovf_ff    <= ovf_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {repeat_ff, alpha_ff, blue_ff, green_ff, red_ff};
   assign rsp_tlast  = done_ff;
   assign rsp_tuser  = ovf_ff;

   // overflow result carries no pixels and never completes the image
   a_ovf_shape: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && ovf_ff) |-> (repeat_ff == 8'd0 && !done_ff))
      else $error("overflow result with pixel count or done flag");

   // completion or overflow stops the decoder
   a_fin_after_end: assert property (@(posedge clock) disable iff (reset)
      (go && rsp_valid_in && (done_in || ovf_in)) |=> fin_ff)
      else $error("decoder not stopped after image end");

   // waiting for a header means no packet is open
   a_header_idle: assert property (@(posedge clock) disable iff (reset)
      !phase_ff |-> (idx_ff == 2'd0 && left_ff == 8'd0))
      else $error("packet state left over while waiting for header");

endmodule

[hw/rtl/tga_rle_pixel_decoder_core.sv]
`timescale 1ns / 1ps

// TGA run-length packet decoder. Takes one packet byte per cycle on req_
// (first_of_image on req_tuser restarts the image) and returns one request on
// rsp_ for each raw pixel and one for each run packet, colour in R,G,B,A order
// with its repeat count; rsp_tlast marks the request that completes
// width*height pixels and rsp_tuser marks the overflow abort. A byte passes an
// input register and then a result register before its result shows on rsp_,
// and bytes stream at one per cycle for as long as the result side keeps up.
// The width*height product is formed on the clock edge of the size write, so
// no settling time is needed after configuration.

module tga_rle_pixel_decoder_core (
   input  logic                         clock,
   input  logic                         reset,
   // configuration
   input  logic                         csr_we,
   input  logic [1:0]                   csr_addr,
   input  logic [tgarle_pkg::REG_W-1:0] csr_wdata,
   // packet byte requests
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [7:0]                   req_tdata,   // in_byte
   input  logic                         req_tuser,   // first_of_image
   // pixel result requests
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [39:0]                  rsp_tdata,   // red, green, blue, alpha, repeat_count
   output logic                         rsp_tlast,   // image_done
   output logic                         rsp_tuser    // overflow_error
);

   tgarle_pkg::cfg_type cfg;

   // configuration registers and pixel total
   tgarle_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // packet decoder
   tgarle_decode u_decode (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps

module tb;

   localparam int SETTLE_CYCLES = 8;     // two register stages plus margin
   localparam int STALL_LIMIT   = 3000;  // cycles without any handshake
   localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
   localparam int PHASE_BYTES   = 52;
   localparam int NUM_PHASES    = 12;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic [7:0] alpha;
      logic [7:0] run_len;
      logic       done;
      logic       overflow;
   } pixel_run_type;

   typedef struct {
      logic [7:0] data;
      logic       first;
   } packet_byte_type;

   // dut ports; the inputs driven by the bench are known from time zero
   logic                         clock      = 1'b0;
   logic                         reset      = 1'b1;
   logic                         csr_we     = 1'b0;
   logic [1:0]                   csr_addr   = '0;
   logic [tgarle_pkg::REG_W-1:0] csr_wdata  = '0;
   logic                         req_tvalid = 1'b0;
   logic                         req_tready;
   logic [7:0]                   req_tdata  = '0;   // in_byte
   logic                         req_tuser  = 1'b0; // first_of_image
   logic                         rsp_tvalid;
   logic                         rsp_tready = 1'b0;
   logic [39:0]                  rsp_tdata;         // red, green, blue, alpha, repeat_count
   logic                         rsp_tlast;         // image_done
   logic                         rsp_tuser;         // overflow_error

   tga_rle_pixel_decoder_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // queues between stimulus, driver and monitor
   packet_byte_type packet_bytes[$];
   pixel_run_type   pixel_runs_due[$];

   // decoder copy used for prediction
   logic [2:0]  bpp_reg    = 3'd3;
   logic [15:0] img_w      = 16'd1;
   logic [15:0] img_h      = 16'd1;
   logic        collecting = 1'b0;
   logic        pkt_run    = 1'b0;
   logic [7:0]  pkt_left   = '0;
   logic [1:0]  byte_idx   = '0;
   logic [7:0]  colour [3] = '{8'd0, 8'd0, 8'd0};
   logic [31:0] pix_count  = '0;
   logic        img_finished = 1'b0;

   // bookkeeping
   int unsigned mismatches   = 0;
   int unsigned bytes_queued = 0;
   int unsigned bytes_taken  = 0;
   int unsigned runs_checked = 0;
   int unsigned overflows    = 0;
   int unsigned images_done  = 0;
   int unsigned settings     = 0;
   int unsigned send_gap     = 0;
   int unsigned recv_gap     = 0;
   int unsigned hold_left    = 0;
   int unsigned quiet_cycles = 0;
   bit          send_smooth  = 1'b0;
   bit          recv_smooth  = 1'b0;

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 3);
      if (r < 92) return $urandom_range(4, 8);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [7:0] rand_colour();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hFF;
      return 8'($urandom_range(0, 255));
   endfunction

   // predict the result of one accepted packet byte
   task automatic decode_byte(input logic [7:0] b, input logic first);
      pixel_run_type r;
      logic [7:0]    cnt;
      logic [1:0]    last_idx;
      logic [63:0]   total;
      total    = 64'(img_w) * 64'(img_h);
      last_idx = (bpp_reg == tgarle_pkg::BPP_WITH_ALPHA) ? tgarle_pkg::LAST_IDX_RGBA
                                                         : tgarle_pkg::LAST_IDX_RGB;
      r        = '0;
      if (first) begin
         collecting   = 1'b0;
         pkt_run      = 1'b0;
         pkt_left     = '0;
         byte_idx     = '0;
         colour       = '{8'd0, 8'd0, 8'd0};
         pix_count    = '0;
         img_finished = 1'b0;
      end
      if (img_finished) return;
      // packet header
      if (!collecting) begin
         if (b < tgarle_pkg::RAW_LIMIT) begin
            pkt_run = 1'b0;
            cnt     = b + 8'd1;
         end else begin
            pkt_run = 1'b1;
            cnt     = b - tgarle_pkg::RUN_BIAS;
         end
         if (64'(pix_count) + 64'(cnt) > total) begin
            r.overflow   = 1'b1;
            img_finished = 1'b1;
            pixel_runs_due.push_back(r);
            return;
         end
         pkt_left   = cnt;
         byte_idx   = '0;
         collecting = 1'b1;
         return;
      end
      // colour bytes before the last one
      if (byte_idx < last_idx) begin
         colour[byte_idx] = b;
         byte_idx         = byte_idx + 2'd1;
         return;
      end
      // last colour byte completes the pixel
      if (last_idx == tgarle_pkg::LAST_IDX_RGB) colour[2] = b;
      cnt       = pkt_run ? pkt_left : 8'd1;
      r.red     = colour[2];
      r.green   = colour[1];
      r.blue    = colour[0];
      r.alpha   = (last_idx == tgarle_pkg::LAST_IDX_RGBA) ? b : 8'd0;
      r.run_len = cnt;
      pix_count = pix_count + 32'(cnt);
      byte_idx  = '0;
      if (pkt_run || pkt_left <= 8'd1) begin
         pkt_left   = '0;
         collecting = 1'b0;
      end else begin
         pkt_left = pkt_left - 8'd1;
      end
      if (64'(pix_count) >= total) begin
         r.done       = 1'b1;
         img_finished = 1'b1;
      end
      pixel_runs_due.push_back(r);
   endtask

   // request driver
   always @(posedge clock) begin
      packet_byte_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            decode_byte(req_tdata, req_tuser);
            bytes_taken++;
         end
         if ($urandom_range(0, 63) == 0) send_smooth = !send_smooth;
         if (!(req_tvalid && !req_tready)) begin
            if (send_gap > 0) begin
               send_gap--;
               req_tvalid <= 1'b0;
            end else if (packet_bytes.size() > 0) begin
               nxt = packet_bytes.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= nxt.data;
               req_tuser  <= nxt.first;
               if (!send_smooth && $urandom_range(0, 99) < 25) send_gap = pick_gap();
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor and checker
   always @(posedge clock) begin
      pixel_run_type got;
      pixel_run_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got = {rsp_tdata[7:0], rsp_tdata[15:8], rsp_tdata[23:16], rsp_tdata[31:24],
                   rsp_tdata[39:32], rsp_tlast, rsp_tuser};
            if (pixel_runs_due.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected pixel run at %0t: %h", $time, got);
            end else begin
               want = pixel_runs_due.pop_front();
               runs_checked++;
               if (want.overflow) overflows++;
               if (want.done) images_done++;
               if (got.red !== want.red || got.green !== want.green ||
                   got.blue !== want.blue || got.alpha !== want.alpha ||
                   got.run_len !== want.run_len || got.done !== want.done ||
                   got.overflow !== want.overflow) begin
                  mismatches++;
                  if (mismatches <= 10) begin
                     $display("mismatch at %0t: want rgba %h %h %h %h n=%0d done=%b ovf=%b",
                              $time, want.red, want.green, want.blue, want.alpha,
                              want.run_len, want.done, want.overflow);
                     $display("                  got rgba %h %h %h %h n=%0d done=%b ovf=%b",
                              got.red, got.green, got.blue, got.alpha,
                              got.run_len, got.done, got.overflow);
                  end
               end
            end
         end
         if ($urandom_range(0, 63) == 0) recv_smooth = !recv_smooth;
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else if (recv_gap > 0) begin
            recv_gap--;
            rsp_tready <= 1'b0;
         end else if (!recv_smooth && $urandom_range(0, 99) < 25) begin
            recv_gap = pick_gap() - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   // watchdog on handshake activity
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
            $display("status: fail");
            $finish;
         end
      end
   end

   task automatic push_byte(input logic [7:0] b, input logic first);
      packet_byte_type p;
      p.data  = b;
      p.first = first;
      packet_bytes.push_back(p);
      bytes_queued++;
   endtask

   task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         tgarle_pkg::CSR_BYTES_PER_PIXEL: bpp_reg = val[2:0];
         tgarle_pkg::CSR_IMAGE_WIDTH:     img_w   = val;
         tgarle_pkg::CSR_IMAGE_HEIGHT:    img_h   = val;
         default: ;
      endcase
   endtask

   // wait until the block has drained, then let the pipeline settle
   task automatic wait_idle();
      while (packet_bytes.size() != 0 || req_tvalid || pixel_runs_due.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // one image as a packet stream, with occasional overflow, truncation and
   // stray restart marks mixed in
   task automatic queue_image(input longint unsigned total, input int unsigned nb,
                              input bit mark);
      longint unsigned left;
      int unsigned     cnt, lim, used, k, j;
      bit              first;
      left  = total;
      first = mark;
      used  = 0;
      if (total == 0) begin
         push_byte(8'($urandom_range(0, 255)), first);
         return;
      end
      while (left > 0) begin
         lim = (left < 128) ? int'(left) : 128;
         if ($urandom_range(0, 99) < 3) first = 1'b1;
         // header that passes the pixel total
         if (left < 128 && $urandom_range(0, 99) < 6) begin
            cnt = $urandom_range(int'(left) + 1, 128);
            if ($urandom_range(0, 1) == 0) push_byte(8'(cnt - 1), first);
            else push_byte(8'(cnt + 127), first);
            return;
         end
         // packet cut short
         if (used > 60 || $urandom_range(0, 99) < 4) begin
            push_byte(8'($urandom_range(0, 255)), first);
            k = $urandom_range(0, nb - 1);
            for (j = 0; j < k; j++) push_byte(rand_colour(), 1'b0);
            return;
         end
         if ($urandom_range(0, 1) == 0) begin
            cnt = ($urandom_range(0, 4) == 0) ? lim : $urandom_range(1, lim);
            push_byte(8'(cnt + 127), first);
            for (j = 0; j < nb; j++) push_byte(rand_colour(), 1'b0);
            used += nb + 1;
         end else begin
            cnt = $urandom_range(1, (lim < 5) ? lim : 5);
            push_byte(8'(cnt - 1), first);
            for (j = 0; j < cnt * nb; j++) push_byte(rand_colour(), 1'b0);
            used += cnt * nb + 1;
         end
         first = 1'b0;
         left -= cnt;
      end
      // trailing bytes after completion are ignored
      if ($urandom_range(0, 4) == 0) begin
         k = $urandom_range(1, 3);
         for (j = 0; j < k; j++) push_byte(8'($urandom_range(0, 255)), 1'b0);
      end
   endtask

   // stimulus sequencing
   initial begin
      int unsigned ph, start, r, nb;
      logic [2:0]  bpp;
      logic [15:0] w, h;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset settings, 3 bytes per pixel, 1x1; first image has no mark
      push_byte(8'h00, 1'b0);
      push_byte(8'h00, 1'b0);
      push_byte(8'h80, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h33, 1'b0);          // ignored once finished
      push_byte(8'h80, 1'b1);          // run of one
      push_byte(8'hFF, 1'b0);
      push_byte(8'h01, 1'b0);
      push_byte(8'h7E, 1'b0);
      push_byte(8'h7F, 1'b1);          // largest raw header overflows
      push_byte(8'hFF, 1'b1);          // largest run header overflows
      wait_idle();

      // alpha, largest image: longest run and a raw packet of two
      write_reg(tgarle_pkg::CSR_BYTES_PER_PIXEL, 16'(tgarle_pkg::BPP_WITH_ALPHA));
      write_reg(tgarle_pkg::CSR_IMAGE_WIDTH, 16'hFFFF);
      write_reg(tgarle_pkg::CSR_IMAGE_HEIGHT, 16'hFFFF);
      settings++;
      @(negedge clock);
      push_byte(8'hFF, 1'b1);
      push_byte(8'h10, 1'b0);
      push_byte(8'h20, 1'b0);
      push_byte(8'h30, 1'b0);
      push_byte(8'hFF, 1'b0);
      push_byte(8'h01, 1'b0);
      for (r = 0; r < 8; r++) push_byte(8'(r * 37), 1'b0);
      wait_idle();

      // zero-sized image: first header always overflows
      write_reg(tgarle_pkg::CSR_IMAGE_WIDTH, 16'h0000);
      write_reg(tgarle_pkg::CSR_BYTES_PER_PIXEL, 16'd7);
      settings++;
      @(negedge clock);
      push_byte(8'h00, 1'b1);
      wait_idle();

      // random phases, each with fresh settings
      for (ph = 0; ph < NUM_PHASES; ph++) begin
         r = $urandom_range(0, 9);
         bpp = (r < 4) ? 3'd3 :
               (r < 8) ? tgarle_pkg::BPP_WITH_ALPHA : 3'($urandom_range(0, 7));
         r = $urandom_range(0, 9);
         if (r < 7) begin
            w = 16'($urandom_range(1, 5));
            h = 16'($urandom_range(1, 5));
         end else if (r == 7) begin
            w = 16'hFFFF;
            h = ($urandom_range(0, 1) == 0) ? 16'hFFFF : 16'd1;
         end else if (r == 8) begin
            w = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom_range(1, 40));
            h = (w == 0) ? 16'($urandom_range(0, 3)) : 16'd0;
         end else begin
            w = 16'($urandom_range(1, 20));
            h = 16'($urandom_range(1, 3));
         end
         if (ph == 0) begin
            w = 16'd1;
            h = 16'd1;
         end
         write_reg(tgarle_pkg::CSR_BYTES_PER_PIXEL, 16'(bpp));
         write_reg(tgarle_pkg::CSR_IMAGE_WIDTH, w);
         write_reg(tgarle_pkg::CSR_IMAGE_HEIGHT, h);
         settings++;
         nb = (bpp == tgarle_pkg::BPP_WITH_ALPHA) ? 4 : 3;
         @(negedge clock);
         start = bytes_queued;
         while (bytes_queued - start < PHASE_BYTES)
            queue_image(longint'(w) * longint'(h), nb, $urandom_range(0, 9) != 0);
         // result side stops while the sender keeps going
         if (ph == 3) hold_left = HOLD_CYCLES;
         wait_idle();
      end

      if (pixel_runs_due.size() != 0) begin
         mismatches += pixel_runs_due.size();
         $display("%0d pixel runs never arrived", pixel_runs_due.size());
      end
      $display("%0d packet bytes over %0d settings gave %0d pixel runs", bytes_taken,
               settings, runs_checked);
      $display("%0d completed images, %0d overflow aborts, %0d mismatches", images_done,
               overflows, mismatches);
      if (mismatches == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
